### design/rcbc_pkg.sv
// Shared types, widths and constants for the residue contact burial classifier.
// Used by rcbc_ctrl, rcbc_dpath and residue_contact_burial_classifier_top.
// No dependencies.
package rcbc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CoordW    = 25;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned SqW       = 2 * DiffW;
  localparam int unsigned SumW      = SqW + 2;
  localparam int unsigned CutoffW   = 48;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CountOutW = 10;
  localparam int unsigned LevelW    = 3;
  localparam int unsigned ClassCntW = 12;
  localparam int unsigned DataW     = 64;
  localparam int unsigned AddrW     = 4;

  // Neighbour count saturates at the top of its output field.
  localparam logic [CountOutW-1:0] CountSat = 10'd1023;

  // Register map: the register index is the top address bit.
  localparam logic RegCutoff = 1'b0;

  // Request codes.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Default squared cutoff: 14 angstrom squared in (1/1000 A)^2.
  localparam logic [CutoffW-1:0] CutoffReset = 48'd196000000;

  // Burial class boundaries on the neighbour count.
  localparam logic [ClassCntW-1:0] Bound1 = 12'd27;
  localparam logic [ClassCntW-1:0] Bound2 = 12'd34;
  localparam logic [ClassCntW-1:0] Bound3 = 12'd40;
  localparam logic [ClassCntW-1:0] Bound4 = 12'd47;
  localparam logic [ClassCntW-1:0] Bound5 = 12'd55;
  localparam logic [ClassCntW-1:0] Bound6 = 12'd66;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // store the accepted point
    logic start;   // capture the accepted query
    logic fetch;   // read the queried point
    logic latch;   // hold the queried point, clear the sweep
    logic scan;    // read the next stored point
    logic result;  // write the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_err;      // accepted query index is not stored
    logic scan_last;  // this read is the last stored point
    logic pipe_busy;  // distance pipeline still holds work
    logic out_free;   // result register can take a new result
  } status_t;

  // Maps a neighbour count to its burial class.
  function automatic logic [LevelW-1:0] burial_class(input logic [ClassCntW-1:0] k);
    logic [LevelW-1:0] lvl;
    if (k < Bound1) begin
      lvl = 3'd0;
    end else if (k < Bound2) begin
      lvl = 3'd1;
    end else if (k < Bound3) begin
      lvl = 3'd2;
    end else if (k < Bound4) begin
      lvl = 3'd3;
    end else if (k < Bound5) begin
      lvl = 3'd4;
    end else if (k < Bound6) begin
      lvl = 3'd5;
    end else begin
      lvl = 3'd6;
    end
    return lvl;
  endfunction

endpackage

### design/rcbc_ctrl.sv
// Sequencing state machine of the residue contact burial classifier.
// Depends on rcbc_pkg for the command and status structs.
module rcbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             req_type_i,
  input  rcbc_pkg::status_t status_i,
  output logic             in_ready_o,
  output rcbc_pkg::cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StFetch  = 6'b000010,
    StLatch  = 6'b000100,
    StScan   = 6'b001000,
    StDrain  = 6'b010000,
    StResult = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // New beats are taken only between queries; loads complete in the accept cycle.
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept & (req_type_i == rcbc_pkg::ReqLoad);
    cmd_o.start  = accept & (req_type_i == rcbc_pkg::ReqQuery);
    cmd_o.fetch  = (state_q == StFetch);
    cmd_o.latch  = (state_q == StLatch);
    cmd_o.scan   = (state_q == StScan);
    cmd_o.result = (state_q == StResult) & status_i.out_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.start) begin
          state_d = status_i.q_err ? StResult : StFetch;
        end
      end
      StFetch: begin
        state_d = StLatch;
      end
      StLatch: begin
        state_d = StScan;
      end
      StScan: begin
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!status_i.pipe_busy) begin
          state_d = StResult;
        end
      end
      StResult: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/rcbc_dpath.sv
// Point store, distance pipeline, neighbour counter and result register.
// Depends on rcbc_pkg; driven by rcbc_ctrl through cmd_t and status_t.
module rcbc_dpath #(
  parameter int unsigned MAX_RESIDUES = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  rcbc_pkg::cmd_t                            cmd_i,
  output rcbc_pkg::status_t                         status_o,
  input  logic [rcbc_pkg::CutoffW-1:0]              cutoff_sq_i,
  input  logic                                      first_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]        cb_x_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]        cb_y_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]        cb_z_i,
  input  logic [rcbc_pkg::IdxW-1:0]                 query_index_i,
  input  logic                                      out_ready_i,
  output logic                                      out_valid_o,
  output logic [rcbc_pkg::IdxW-1:0]                 residue_index_o,
  output logic [rcbc_pkg::CountOutW-1:0]            neighbor_count_o,
  output logic [rcbc_pkg::LevelW-1:0]               burial_level_o,
  output logic                                      index_error_o
);

  localparam int unsigned AW = $clog2(MAX_RESIDUES);
  localparam int unsigned CW = $clog2(MAX_RESIDUES + 1);
  localparam int unsigned IW = (AW > rcbc_pkg::IdxW) ? AW : rcbc_pkg::IdxW;
  localparam int unsigned CoW = rcbc_pkg::CoordW;
  localparam int unsigned PW = 3 * CoW;

  // Residue count and store write side.
  logic [CW-1:0] cnt_q, cnt_d;
  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign full    = (cnt_q >= CW'(MAX_RESIDUES));
  assign wr_en   = cmd_i.load & (first_i | ~full);
  assign wr_addr = first_i ? '0 : cnt_q[AW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      if (first_i) begin
        cnt_d = CW'(1);
      end else if (!full) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Query capture and range check.
  logic [rcbc_pkg::IdxW-1:0] qidx_q;
  logic                      err_q;
  logic [IW-1:0]             qidx_w;
  logic [AW-1:0]             qaddr;
  logic                      q_err_now;

  assign q_err_now = {1'b0, IW'(query_index_i)} >= (IW + 1)'(cnt_q);
  assign qidx_w    = IW'(qidx_q);
  assign qaddr     = qidx_w[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qidx_q <= query_index_i;
      err_q  <= q_err_now;
    end
  end

  // Point memory: one write port for loads, one registered read port.
  logic [PW-1:0] mem [MAX_RESIDUES];
  logic [PW-1:0] rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] j_q;

  assign rd_en   = cmd_i.fetch | cmd_i.scan;
  assign rd_addr = cmd_i.fetch ? qaddr : j_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {cb_x_i, cb_y_i, cb_z_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Queried point held for the whole sweep.
  logic signed [CoW-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      px_q <= signed'(rd_q[3*CoW-1:2*CoW]);
      py_q <= signed'(rd_q[2*CoW-1:CoW]);
      pz_q <= signed'(rd_q[CoW-1:0]);
    end
  end

  // Sweep index over the stored points.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.latch) begin
      j_q <= '0;
    end else if (cmd_i.scan) begin
      j_q <= j_q + AW'(1);
    end
  end

  // Pipeline valid flags; the queried residue itself is never marked valid.
  logic va_q, vb_q, vc_q, vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= cmd_i.scan & (j_q != qaddr);
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // Stage B: absolute coordinate differences.
  logic signed [rcbc_pkg::DiffW-1:0] dx, dy, dz;
  logic [rcbc_pkg::DiffW-1:0]        ax_q, ay_q, az_q;

  assign dx = rcbc_pkg::DiffW'(px_q) - rcbc_pkg::DiffW'(signed'(rd_q[3*CoW-1:2*CoW]));
  assign dy = rcbc_pkg::DiffW'(py_q) - rcbc_pkg::DiffW'(signed'(rd_q[2*CoW-1:CoW]));
  assign dz = rcbc_pkg::DiffW'(pz_q) - rcbc_pkg::DiffW'(signed'(rd_q[CoW-1:0]));

  always_ff @(posedge clk_i) begin
    ax_q <= dx[rcbc_pkg::DiffW-1] ? -dx : dx;
    ay_q <= dy[rcbc_pkg::DiffW-1] ? -dy : dy;
    az_q <= dz[rcbc_pkg::DiffW-1] ? -dz : dz;
  end

  // Stage C: one squaring multiplier per axis.
  logic [rcbc_pkg::SqW-1:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    sx_q <= ax_q * ax_q;
    sy_q <= ay_q * ay_q;
    sz_q <= az_q * az_q;
  end

  // Stage D: squared distance.
  logic [rcbc_pkg::SumW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q <= rcbc_pkg::SumW'(sx_q) + rcbc_pkg::SumW'(sy_q) + rcbc_pkg::SumW'(sz_q);
  end

  // Neighbour counter.
  logic [AW-1:0] nc_q;
  logic          hit;

  assign hit = vd_q & (sum_q <= rcbc_pkg::SumW'(cutoff_sq_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q <= '0;
    end else if (cmd_i.latch) begin
      nc_q <= '0;
    end else if (hit) begin
      nc_q <= nc_q + AW'(1);
    end
  end

  // Result formatting: the count saturates, the class uses the full count.
  logic [IW-1:0]                     nc_w;
  logic [rcbc_pkg::CountOutW-1:0]    nc_sat;
  logic [rcbc_pkg::LevelW-1:0]       level;

  assign nc_w   = IW'(nc_q);
  assign nc_sat = (nc_w > IW'(rcbc_pkg::CountSat)) ? rcbc_pkg::CountSat
                                                   : nc_w[rcbc_pkg::CountOutW-1:0];
  assign level  = rcbc_pkg::burial_class(rcbc_pkg::ClassCntW'(nc_q));

  // Result register parts the output beat from the sweep.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      residue_index_o  <= qidx_q;
      neighbor_count_o <= err_q ? '0 : nc_sat;
      burial_level_o   <= err_q ? '0 : level;
      index_error_o    <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status back to the controller.
  always_comb begin
    status_o           = '0;
    status_o.q_err     = q_err_now;
    status_o.scan_last = ((CW'(j_q) + CW'(1)) == cnt_q);
    status_o.pipe_busy = va_q | vb_q | vc_q | vd_q;
    status_o.out_free  = ~out_valid_q | out_ready_i;
  end

  // The stored count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RESIDUES))
    else $error("residue count beyond capacity");

  // The sweep reads only stored entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (CW'(j_q) < cnt_q))
    else $error("sweep read past stored count");

  // A result is never written over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // An out-of-range query reports a zero count and class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_error_o) |-> (neighbor_count_o == '0 && burial_level_o == '0))
    else $error("index error with non-zero count");

endmodule

### design/residue_contact_burial_classifier_top.sv
// Top level of the residue contact burial classifier: register port and instances.
// Depends on rcbc_pkg, rcbc_ctrl and rcbc_dpath.
//
// Input channel (in_valid_i / in_ready_o) carries one beat per request. A load
// beat stores one point and completes in its accept cycle, so loads stream at
// one per cycle while no query is in work. A load with first_i set empties the
// store first; a load into a full store is dropped. A query beat is answered
// by one beat on the output channel (out_valid_o / out_ready_i) once the point
// memory's single read port has visited every stored point, one per cycle. A
// query past the stored count skips the sweep and goes straight to the result
// state, with index_error_o set. No further input beat is taken while a query
// is in work.
// A finished result sits in an output register, so a new request is taken while
// the receiver stalls; a later query then waits for that register to empty.
// Reset empties the store, restores the squared cutoff for a 14 angstrom
// contact distance and drops any pending result. The cutoff register sits at
// address 0 and should be written only while the block is idle.
module residue_contact_burial_classifier_top #(
  parameter int unsigned MAX_RESIDUES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcbc_pkg::AddrW-1:0]          paddr,
  input  logic [rcbc_pkg::DataW-1:0]          pwdata,
  output logic [rcbc_pkg::DataW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic                                first_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]  cb_x_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]  cb_y_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]  cb_z_i,
  input  logic [rcbc_pkg::IdxW-1:0]           query_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rcbc_pkg::IdxW-1:0]           residue_index_o,
  output logic [rcbc_pkg::CountOutW-1:0]      neighbor_count_o,
  output logic [rcbc_pkg::LevelW-1:0]         burial_level_o,
  output logic                                index_error_o
);

  // Cutoff register behind the APB port.
  logic [rcbc_pkg::CutoffW-1:0] cutoff_q;
  logic                         sel_cutoff;
  logic                         wr_cutoff;

  assign pready     = 1'b1;
  assign sel_cutoff = (paddr[rcbc_pkg::AddrW-1] == rcbc_pkg::RegCutoff);
  assign wr_cutoff  = psel & penable & pwrite & pready & sel_cutoff;
  assign prdata     = sel_cutoff ? rcbc_pkg::DataW'(cutoff_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= rcbc_pkg::CutoffReset;
    end else if (wr_cutoff) begin
      cutoff_q <= pwdata[rcbc_pkg::CutoffW-1:0];
    end
  end

  // Controller and datapath.
  rcbc_pkg::cmd_t    cmd;
  rcbc_pkg::status_t status;

  rcbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rcbc_dpath #(
    .MAX_RESIDUES (MAX_RESIDUES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cutoff_sq_i      (cutoff_q),
    .first_i          (first_i),
    .cb_x_i           (cb_x_i),
    .cb_y_i           (cb_y_i),
    .cb_z_i           (cb_z_i),
    .query_index_i    (query_index_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .residue_index_o  (residue_index_o),
    .neighbor_count_o (neighbor_count_o),
    .burial_level_o   (burial_level_o),
    .index_error_o    (index_error_o)
  );

endmodule

### tb/rcbc_burial_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the residue contact burial classifier: follows the register port and
// both beat channels, predicts every query result and compares it field by field.
// Depends on rcbc_pkg.
module rcbc_burial_checker #(
  parameter int unsigned MAX_RESIDUES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcbc_pkg::AddrW-1:0]          paddr,
  input  logic [rcbc_pkg::DataW-1:0]          pwdata,
  input  logic [rcbc_pkg::DataW-1:0]          prdata,
  input  logic                                pready,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                req_type_i,
  input  logic                                first_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]  cb_x_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]  cb_y_i,
  input  logic signed [rcbc_pkg::CoordW-1:0]  cb_z_i,
  input  logic [rcbc_pkg::IdxW-1:0]           query_index_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [rcbc_pkg::IdxW-1:0]           residue_index_i,
  input  logic [rcbc_pkg::CountOutW-1:0]      neighbor_count_i,
  input  logic [rcbc_pkg::LevelW-1:0]         burial_level_i,
  input  logic                                index_error_i,
  output int                                  mismatches_o,
  output int                                  results_owed_o
);

  localparam logic [rcbc_pkg::AddrW-1:0] CutoffAddr = {rcbc_pkg::RegCutoff, 3'b000};

  // One result beat as the block should present it.
  typedef struct packed {
    logic [rcbc_pkg::IdxW-1:0]      residue_index;
    logic [rcbc_pkg::CountOutW-1:0] neighbor_count;
    logic [rcbc_pkg::LevelW-1:0]    burial_level;
    logic                           index_error;
  } burial_t;

  // Own copy of the point store, the stored count and the cutoff.
  logic signed [rcbc_pkg::CoordW-1:0] site_x [MAX_RESIDUES];
  logic signed [rcbc_pkg::CoordW-1:0] site_y [MAX_RESIDUES];
  logic signed [rcbc_pkg::CoordW-1:0] site_z [MAX_RESIDUES];
  int unsigned                        site_count;
  logic [rcbc_pkg::CutoffW-1:0]       contact_cutoff;
  burial_t                            owed_burials [$];
  int                                 fault_count = 0;

  // Squared difference along one axis, exact in 64 bits.
  function automatic longint unsigned axis_sq(logic signed [rcbc_pkg::CoordW-1:0] a,
                                              logic signed [rcbc_pkg::CoordW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) begin
      d = -d;
    end
    return d * d;
  endfunction

  // Burial class from the unsaturated neighbour count.
  function automatic logic [rcbc_pkg::LevelW-1:0] burial_band(int unsigned k);
    if (k < 27) return 3'd0;
    if (k < 34) return 3'd1;
    if (k < 40) return 3'd2;
    if (k < 47) return 3'd3;
    if (k < 55) return 3'd4;
    if (k < 66) return 3'd5;
    return 3'd6;
  endfunction

  // Counts the stored residues within the cutoff of the queried one.
  function automatic burial_t classify(logic [rcbc_pkg::IdxW-1:0] idx);
    burial_t           r;
    int unsigned       k;
    int unsigned       j;
    longint unsigned   d2;
    r.residue_index  = idx;
    r.neighbor_count = '0;
    r.burial_level   = '0;
    r.index_error    = 1'b1;
    if (idx < site_count) begin
      k = 0;
      for (j = 0; j < site_count; j++) begin
        if (j != idx) begin
          d2 = axis_sq(site_x[idx], site_x[j]) + axis_sq(site_y[idx], site_y[j])
             + axis_sq(site_z[idx], site_z[j]);
          if (d2 <= contact_cutoff) begin
            k++;
          end
        end
      end
      r.neighbor_count = (k > rcbc_pkg::CountSat) ? rcbc_pkg::CountSat
                                                  : k[rcbc_pkg::CountOutW-1:0];
      r.burial_level   = burial_band(k);
      r.index_error    = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    burial_t seen;
    burial_t want;
    if (!rst_ni) begin
      site_count     = 0;
      contact_cutoff = rcbc_pkg::CutoffReset;
      owed_burials.delete();
    end else begin
      // Register port: a write moves the cutoff, a read must return it.
      if (psel && penable && pready && paddr == CutoffAddr) begin
        if (pwrite) begin
          contact_cutoff = pwdata[rcbc_pkg::CutoffW-1:0];
        end else begin
          check_field("cutoff_sq", 64'(contact_cutoff),
                      64'(prdata[rcbc_pkg::CutoffW-1:0]));
        end
      end

      // Result beat: compared with the oldest query still owed.
      if (out_valid_i && out_ready_i) begin
        seen.residue_index  = residue_index_i;
        seen.neighbor_count = neighbor_count_i;
        seen.burial_level   = burial_level_i;
        seen.index_error    = index_error_i;
        if (owed_burials.size() == 0) begin
          $error("result beat for residue %0d with no query waiting", residue_index_i);
          fault_count++;
        end else begin
          want = owed_burials.pop_front();
          check_field("residue_index", 64'(want.residue_index), 64'(seen.residue_index));
          check_field("neighbor_count", 64'(want.neighbor_count), 64'(seen.neighbor_count));
          check_field("burial_level", 64'(want.burial_level), 64'(seen.burial_level));
          check_field("index_error", 64'(want.index_error), 64'(seen.index_error));
        end
      end

      // Request beat: a load updates the store, a query owes one result.
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == rcbc_pkg::ReqLoad) begin
          if (first_i) begin
            site_count = 0;
          end
          if (site_count < MAX_RESIDUES) begin
            site_x[site_count] = cb_x_i;
            site_y[site_count] = cb_y_i;
            site_z[site_count] = cb_z_i;
            site_count++;
          end
        end else begin
          owed_burials = {owed_burials, classify(query_index_i)};
        end
      end
    end
    mismatches_o   <= fault_count;
    results_owed_o <= owed_burials.size();
  end

endmodule

### tb/residue_contact_burial_classifier_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the residue contact burial classifier: clock, reset, register
// writes, request and result traffic, and the verdict.
// Depends on rcbc_pkg, residue_contact_burial_classifier_top and rcbc_burial_checker.
module residue_contact_burial_classifier_top_test;

  localparam int unsigned MaxResidues   = 1024;
  localparam int unsigned CycleLimit    = 5000000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned PhaseItems    = 110;
  localparam logic [rcbc_pkg::AddrW-1:0] CutoffAddr = {rcbc_pkg::RegCutoff, 3'b000};
  localparam longint CoordMax = 16777215;
  localparam longint CoordMin = -16777216;
  localparam logic signed [rcbc_pkg::CoordW-1:0] CoordHi =
    {1'b0, {(rcbc_pkg::CoordW-1){1'b1}}};
  localparam logic signed [rcbc_pkg::CoordW-1:0] CoordLo =
    {1'b1, {(rcbc_pkg::CoordW-1){1'b0}}};

  logic                                 clk_i            = 1'b0;
  logic                                 rst_ni           = 1'b0;
  logic                                 psel             = 1'b0;
  logic                                 penable          = 1'b0;
  logic                                 pwrite           = 1'b0;
  logic [rcbc_pkg::AddrW-1:0]           paddr            = '0;
  logic [rcbc_pkg::DataW-1:0]           pwdata           = '0;
  logic [rcbc_pkg::DataW-1:0]           prdata;
  logic                                 pready;
  logic                                 in_valid_i       = 1'b0;
  logic                                 in_ready_o;
  logic                                 req_type_i       = rcbc_pkg::ReqLoad;
  logic                                 first_i          = 1'b0;
  logic signed [rcbc_pkg::CoordW-1:0]   cb_x_i           = '0;
  logic signed [rcbc_pkg::CoordW-1:0]   cb_y_i           = '0;
  logic signed [rcbc_pkg::CoordW-1:0]   cb_z_i           = '0;
  logic [rcbc_pkg::IdxW-1:0]            query_index_i    = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i      = 1'b0;
  logic [rcbc_pkg::IdxW-1:0]            residue_index_o;
  logic [rcbc_pkg::CountOutW-1:0]       neighbor_count_o;
  logic [rcbc_pkg::LevelW-1:0]          burial_level_o;
  logic                                 index_error_o;

  int          mismatches;
  int          results_owed;
  int          cycles       = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          hold_len     = 0;
  int unsigned reach        = 14000;
  int unsigned stored       = 0;
  int unsigned items_sent   = 0;
  int unsigned loads_sent   = 0;
  int unsigned queries_sent = 0;
  longint      centre_x     = 0;
  longint      centre_y     = 0;
  longint      centre_z     = 0;

  residue_contact_burial_classifier_top dut (.*);

  rcbc_burial_checker #(
    .MAX_RESIDUES(MaxResidues)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .first_i          (first_i),
    .cb_x_i           (cb_x_i),
    .cb_y_i           (cb_y_i),
    .cb_z_i           (cb_z_i),
    .query_index_i    (query_index_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .residue_index_i  (residue_index_o),
    .neighbor_count_i (neighbor_count_o),
    .burial_level_i   (burial_level_o),
    .index_error_i    (index_error_o),
    .mismatches_o     (mismatches),
    .results_owed_o   (results_owed)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("run stopped after %0d cycles with %0d results owed", cycles, results_owed);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        repeat (n) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic signed [rcbc_pkg::CoordW-1:0] rand_coord();
    logic [31:0] w;
    w = $urandom();
    return w[rcbc_pkg::CoordW-1:0];
  endfunction

  // A coordinate within span of a centre, clamped to the field.
  function automatic logic signed [rcbc_pkg::CoordW-1:0] near(longint centre,
                                                              int unsigned span);
    longint v;
    v = centre + longint'($urandom_range(2 * span)) - longint'(span);
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v[rcbc_pkg::CoordW-1:0];
  endfunction

  // Cluster spread: tight enough for dense contacts, or loose.
  function automatic int unsigned pick_span();
    case ($urandom_range(2))
      0:       return reach >> 2;
      1:       return reach;
      default: return reach * 2;
    endcase
  endfunction

  // Mostly stored residues, sometimes the one just past the end or any index.
  function automatic logic [rcbc_pkg::IdxW-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(9);
    if (stored == 0 || r == 0) return rcbc_pkg::IdxW'($urandom());
    if (r == 1 && stored < MaxResidues) return rcbc_pkg::IdxW'(stored);
    return rcbc_pkg::IdxW'($urandom_range(stored - 1));
  endfunction

  // Presents one beat, holds it until taken, then idles at random.
  task automatic send_beat(logic kind, logic clear, logic signed [rcbc_pkg::CoordW-1:0] x,
                           logic signed [rcbc_pkg::CoordW-1:0] y,
                           logic signed [rcbc_pkg::CoordW-1:0] z,
                           logic [rcbc_pkg::IdxW-1:0] idx);
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    first_i       <= clear;
    cb_x_i        <= x;
    cb_y_i        <= y;
    cb_z_i        <= z;
    query_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (kind == rcbc_pkg::ReqLoad) begin
      loads_sent++;
      if (clear) begin
        stored = 1;
      end else if (stored < MaxResidues) begin
        stored++;
      end
    end else begin
      queries_sent++;
    end
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_load(logic clear, logic signed [rcbc_pkg::CoordW-1:0] x,
                           logic signed [rcbc_pkg::CoordW-1:0] y,
                           logic signed [rcbc_pkg::CoordW-1:0] z);
    send_beat(rcbc_pkg::ReqLoad, clear, x, y, z, rcbc_pkg::IdxW'($urandom()));
  endtask

  // Unused fields of a query carry random bits.
  task automatic send_query(logic [rcbc_pkg::IdxW-1:0] idx);
    send_beat(rcbc_pkg::ReqQuery, 1'($urandom()), rand_coord(), rand_coord(), rand_coord(),
              idx);
  endtask

  // Starts a fresh set of points around a random centre.
  task automatic load_cluster(int unsigned size, int unsigned span);
    centre_x = rand_coord();
    centre_y = rand_coord();
    centre_z = rand_coord();
    for (int unsigned i = 0; i < size; i++) begin
      send_load(i == 0, near(centre_x, span), near(centre_y, span), near(centre_z, span));
    end
  endtask

  // Stops offering, waits for every owed result, then lets the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the cutoff and reads it back; the span sets cluster spreads to match.
  task automatic write_cutoff(logic [rcbc_pkg::CutoffW-1:0] value, int unsigned span);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CutoffAddr;
    pwdata  <= {{(rcbc_pkg::DataW-rcbc_pkg::CutoffW){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reach = span;
  endtask

  // Mostly well-formed sets followed by queries, with some growth and noise.
  task automatic random_phase(int unsigned n);
    int unsigned goal;
    int unsigned pick;
    int unsigned size;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        pick = $urandom_range(19);
        if (pick == 0) begin
          size = $urandom_range(91, 250);
        end else if (pick < 6) begin
          size = $urandom_range(41, 90);
        end else begin
          size = $urandom_range(1, 40);
        end
        load_cluster(size, pick_span());
        repeat ($urandom_range(2, 8)) send_query(pick_index());
      end else if (pick < 80) begin
        // Grow the current set a little and ask again.
        repeat ($urandom_range(1, 5)) begin
          send_load(1'b0, near(centre_x, reach), near(centre_y, reach), near(centre_z, reach));
        end
        repeat ($urandom_range(1, 3)) send_query(pick_index());
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_query(pick_index());
      end else begin
        // Noise: any request with any content.
        repeat ($urandom_range(1, 4)) begin
          send_beat(1'($urandom()), 1'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                    rcbc_pkg::IdxW'($urandom()));
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned span;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats under the reset cutoff: empty store, a pair exactly on the
    // cutoff, one just outside, field extremes, queries at and past the end,
    // and a fresh start in the middle of a set.
    send_query(10'd0);
    send_load(1'b1, 25'sd0, 25'sd0, 25'sd0);
    send_load(1'b0, 25'sd14000, 25'sd0, 25'sd0);
    send_load(1'b0, 25'sd0, 25'sd14001, 25'sd0);
    send_load(1'b0, CoordLo, CoordLo, CoordLo);
    send_load(1'b0, CoordHi, CoordHi, CoordHi);
    send_load(1'b0, CoordHi, CoordLo, CoordHi);
    send_query(10'd0);
    send_query(10'd1);
    send_query(10'd2);
    send_query(10'd4);
    send_query(10'd5);
    send_query(10'd6);
    send_query(10'd1023);
    send_load(1'b1, CoordHi, CoordLo, 25'sd1);
    send_query(10'd0);
    send_query(10'd1);
    settle();

    // Nominal cutoff, no idling.
    write_cutoff(rcbc_pkg::CutoffReset, 14000);
    idle_pct  = 0;
    stall_pct = 0;
    random_phase(PhaseItems);
    settle();

    // Zero cutoff: only coincident points touch; sender mostly idle.
    write_cutoff('0, 2);
    idle_pct  = 79;
    stall_pct = 0;
    random_phase(PhaseItems);
    settle();

    // Largest cutoff with points across the whole field; receiver mostly stalled.
    write_cutoff('1, 16777215);
    idle_pct  = 0;
    stall_pct = 79;
    random_phase(PhaseItems);
    settle();

    // Random radius, light idling on both sides, and a long receiver hold-off
    // while queries keep coming so the input side backs up.
    span = $urandom_range(1, 8388608);
    write_cutoff(rcbc_pkg::CutoffW'(longint'(span) * longint'(span)), span);
    idle_pct  = 10;
    stall_pct = 10;
    load_cluster(24, reach);
    hold_len = HoldOffCycles;
    repeat (6) send_query(pick_index());
    random_phase(PhaseItems);
    settle();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d load beats and %0d query beats over five cutoff phases,",
             loads_sent, queries_sent);
    $display("with idling and stalls on both channels and a long receiver hold-off.");
    if (mismatches == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### residue_contact_burial_classifier_top.f
design/rcbc_pkg.sv
design/rcbc_ctrl.sv
design/rcbc_dpath.sv
design/residue_contact_burial_classifier_top.sv
tb/rcbc_burial_checker.sv
tb/residue_contact_burial_classifier_top_test.sv
